### design/hcti_pkg.sv
// hcti_pkg: shared types and constants for the hollow-cone track isolation block.
// Holds the controller state type, register codes and the control/status structs.
// No dependencies.
package hcti_pkg;

  localparam int unsigned PT_W       = 16;
  localparam int unsigned ETA_W      = 14;
  localparam int unsigned PHI_W      = 13;
  localparam int unsigned AETA_W     = 13;
  localparam int unsigned DSQ_W      = 29;
  localparam int unsigned TIV_W      = 16;
  localparam int unsigned HITS_W     = 10;
  localparam int unsigned THIT_W     = 6;
  localparam int unsigned PHIT_W     = 4;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 29;

  localparam logic signed [ETA_W-1:0] PHI_HALF_TURN = 14'sd3217;
  localparam logic signed [ETA_W-1:0] PHI_FULL_TURN = 14'sd6434;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MIN_PT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_MIN_PT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ABS_ETA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_INNER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_OUTER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TIV      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_MINIMUMS = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS   = 3'd7;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SEED_RD,
    S_SEED_CHK,
    S_SCAN,
    S_DRAIN,
    S_DIV,
    S_NEXT,
    S_FINISH
  } hcti_state_t;

  typedef struct packed {
    logic load_en;
    logic clr_scan;
    logic rd_seed;
    logic latch_seed;
    logic inc_i;
    logic scan_issue;
    logic div_start;
    logic upd_best;
    logic finish;
  } hcti_cmd_t;

  typedef struct packed {
    logic i_done;
    logic is_seed;
    logic j_last;
    logic pipe_busy;
    logic div_busy;
    logic out_blocked;
  } hcti_sts_t;

endpackage

### design/hcti_ctrl.sv
// hcti_ctrl: sequencer for track loading, the per-seed cone scan and the divide.
// Depends on hcti_pkg.
module hcti_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_track,
  input  hcti_pkg::hcti_sts_t sts,
  output hcti_pkg::hcti_cmd_t cmd
);

  hcti_pkg::hcti_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hcti_pkg::S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hcti_pkg::S_LOAD: begin
        if (in_valid && in_last_track) state_nxt = hcti_pkg::S_SEED_RD;
      end
      hcti_pkg::S_SEED_RD: begin
        state_nxt = sts.i_done ? hcti_pkg::S_FINISH : hcti_pkg::S_SEED_CHK;
      end
      hcti_pkg::S_SEED_CHK: begin
        state_nxt = sts.is_seed ? hcti_pkg::S_SCAN : hcti_pkg::S_SEED_RD;
      end
      hcti_pkg::S_SCAN: begin
        if (sts.j_last) state_nxt = hcti_pkg::S_DRAIN;
      end
      hcti_pkg::S_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = hcti_pkg::S_DIV;
      end
      hcti_pkg::S_DIV: begin
        if (!sts.div_busy) state_nxt = hcti_pkg::S_NEXT;
      end
      hcti_pkg::S_NEXT: begin
        state_nxt = hcti_pkg::S_SEED_RD;
      end
      hcti_pkg::S_FINISH: begin
        if (!sts.out_blocked) state_nxt = hcti_pkg::S_LOAD;
      end
      default: state_nxt = hcti_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      hcti_pkg::S_LOAD: begin
        cmd.load_en  = 1'b1;
        cmd.clr_scan = 1'b1;
      end
      hcti_pkg::S_SEED_RD: begin
        cmd.rd_seed = !sts.i_done;
      end
      hcti_pkg::S_SEED_CHK: begin
        cmd.latch_seed = sts.is_seed;
        cmd.inc_i      = !sts.is_seed;
      end
      hcti_pkg::S_SCAN: begin
        cmd.scan_issue = 1'b1;
      end
      hcti_pkg::S_DRAIN: begin
        cmd.div_start = !sts.pipe_busy;
      end
      hcti_pkg::S_DIV: begin
      end
      hcti_pkg::S_NEXT: begin
        cmd.upd_best = 1'b1;
        cmd.inc_i    = 1'b1;
      end
      hcti_pkg::S_FINISH: begin
        cmd.finish = !sts.out_blocked;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### design/hcti_dp.sv
// hcti_dp: config registers, track store, cone distance pipeline, pt sums,
// serial divider and the result register. Depends on hcti_pkg.
module hcti_dp #(
  parameter int unsigned MAX_TRACKS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hcti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hcti_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  input  logic [hcti_pkg::PT_W-1:0]            in_track_pt,
  input  logic signed [hcti_pkg::ETA_W-1:0]    in_track_eta,
  input  logic signed [hcti_pkg::PHI_W-1:0]    in_track_phi,
  input  logic [hcti_pkg::THIT_W-1:0]          in_tracker_hit_count,
  input  logic [hcti_pkg::PHIT_W-1:0]          in_pixel_hit_count,
  input  logic                                 in_high_purity,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [hcti_pkg::TIV_W-1:0]           out_min_isolation_ratio,
  output logic                                 out_no_seed,
  output logic                                 out_event_accept,
  output logic                                 out_tracks_dropped,
  input  hcti_pkg::hcti_cmd_t                  cmd,
  output hcti_pkg::hcti_sts_t                  sts
);

  localparam int unsigned IW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW    = $clog2(MAX_TRACKS + 1);
  localparam int unsigned SW    = CW + hcti_pkg::PT_W;
  localparam int unsigned NW    = SW + 8;
  localparam int unsigned DCW   = $clog2(NW + 1);
  localparam int unsigned ENT_W = hcti_pkg::PT_W + hcti_pkg::ETA_W + hcti_pkg::PHI_W;

  // config
  logic [hcti_pkg::PT_W-1:0]   track_min_pt_r, seed_min_pt_r;
  logic [hcti_pkg::AETA_W-1:0] max_abs_eta_r;
  logic [hcti_pkg::DSQ_W-1:0]  cone_inner_r, cone_outer_r;
  logic [hcti_pkg::TIV_W-1:0]  min_tiv_r;
  logic [hcti_pkg::HITS_W-1:0] hit_min_r;
  logic [hcti_pkg::MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_min_pt_r <= 16'd16;
      seed_min_pt_r  <= 16'd320;
      max_abs_eta_r  <= 13'd2560;
      cone_inner_r   <= 29'd10486;
      cone_outer_r   <= 29'd262144;
      min_tiv_r      <= 16'd0;
      hit_min_r      <= 10'd8;
      mode_r         <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hcti_pkg::REG_TRACK_MIN_PT: track_min_pt_r <= cfg_wdata[15:0];
        hcti_pkg::REG_SEED_MIN_PT:  seed_min_pt_r  <= cfg_wdata[15:0];
        hcti_pkg::REG_MAX_ABS_ETA:  max_abs_eta_r  <= cfg_wdata[12:0];
        hcti_pkg::REG_CONE_INNER:   cone_inner_r   <= cfg_wdata[28:0];
        hcti_pkg::REG_CONE_OUTER:   cone_outer_r   <= cfg_wdata[28:0];
        hcti_pkg::REG_MIN_TIV:      min_tiv_r      <= cfg_wdata[15:0];
        hcti_pkg::REG_HIT_MINIMUMS: hit_min_r      <= cfg_wdata[9:0];
        hcti_pkg::REG_MODE_FLAGS:   mode_r         <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // track cuts
  logic [hcti_pkg::ETA_W-1:0] abs_eta;
  logic                       pass;
  logic                       accept_beat;

  assign abs_eta = in_track_eta[hcti_pkg::ETA_W-1] ? (~in_track_eta + 14'd1) : in_track_eta;
  assign pass = (!mode_r[0] || in_high_purity)
             && (in_tracker_hit_count >= hit_min_r[5:0])
             && (in_pixel_hit_count >= hit_min_r[9:6])
             && (in_track_pt >= track_min_pt_r)
             && (abs_eta <= {1'b0, max_abs_eta_r});
  assign accept_beat = in_valid && cmd.load_en;

  // store
  logic [ENT_W-1:0] mem [MAX_TRACKS];
  logic [ENT_W-1:0] rdata_r;
  logic [CW-1:0]    count_r, i_r, j_r;
  logic             overflow_r;
  logic             store_wr;
  logic [IW-1:0]    rd_addr;

  assign store_wr = accept_beat && pass && (count_r < CW'(MAX_TRACKS));
  assign rd_addr  = cmd.rd_seed ? i_r[IW-1:0] : j_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (store_wr) mem[count_r[IW-1:0]] <= {in_track_pt, in_track_eta, in_track_phi};
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (cmd.finish) begin
      count_r    <= '0;
      overflow_r <= 1'b0;
    end else if (accept_beat && pass) begin
      if (store_wr) count_r <= count_r + CW'(1);
      else          overflow_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_scan) begin
      i_r <= '0;
    end else if (cmd.inc_i) begin
      i_r <= i_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch_seed) begin
      j_r <= '0;
    end else if (cmd.scan_issue) begin
      j_r <= j_r + CW'(1);
    end
  end

  logic [hcti_pkg::PT_W-1:0]         rd_pt;
  logic signed [hcti_pkg::ETA_W-1:0] rd_eta;
  logic signed [hcti_pkg::PHI_W-1:0] rd_phi;
  assign rd_pt  = rdata_r[ENT_W-1 -: hcti_pkg::PT_W];
  assign rd_eta = rdata_r[hcti_pkg::PHI_W +: hcti_pkg::ETA_W];
  assign rd_phi = rdata_r[hcti_pkg::PHI_W-1:0];

  // seed
  logic [hcti_pkg::PT_W-1:0]         seed_pt_r;
  logic signed [hcti_pkg::ETA_W-1:0] seed_eta_r;
  logic signed [hcti_pkg::PHI_W-1:0] seed_phi_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_seed) begin
      seed_pt_r  <= rd_pt;
      seed_eta_r <= rd_eta;
      seed_phi_r <= rd_phi;
    end
  end

  // distance pipeline
  logic                              v0_r, v1_r, v2_r;
  logic signed [hcti_pkg::ETA_W:0]   deta;
  logic signed [hcti_pkg::ETA_W-1:0] dphi_raw, dphi_a, dphi_b;
  logic signed [hcti_pkg::ETA_W:0]   deta_r;
  logic signed [hcti_pkg::PHI_W-1:0] dphi_r;
  logic [hcti_pkg::PT_W-1:0]         pt1_r, pt2_r;
  logic signed [29:0]                eta_prod;
  logic signed [25:0]                phi_prod;
  logic [27:0]                       eta_sq_r;
  logic [23:0]                       phi_sq_r;
  logic [hcti_pkg::DSQ_W-1:0]        dr_sq;
  logic                              in_cone;

  assign deta     = $signed({seed_eta_r[hcti_pkg::ETA_W-1], seed_eta_r})
                  - $signed({rd_eta[hcti_pkg::ETA_W-1], rd_eta});
  assign dphi_raw = $signed({seed_phi_r[hcti_pkg::PHI_W-1], seed_phi_r})
                  - $signed({rd_phi[hcti_pkg::PHI_W-1], rd_phi});
  assign dphi_a   = (dphi_raw >= hcti_pkg::PHI_HALF_TURN) ? dphi_raw - hcti_pkg::PHI_FULL_TURN
                                                          : dphi_raw;
  assign dphi_b   = (dphi_a <= -hcti_pkg::PHI_HALF_TURN) ? dphi_a + hcti_pkg::PHI_FULL_TURN
                                                         : dphi_a;
  assign eta_prod = deta_r * deta_r;
  assign phi_prod = dphi_r * dphi_r;
  assign dr_sq    = {1'b0, eta_sq_r} + {5'd0, phi_sq_r};
  assign in_cone  = (dr_sq >= cone_inner_r) && (dr_sq <= cone_outer_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= cmd.scan_issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    deta_r   <= deta;
    dphi_r   <= dphi_b[hcti_pkg::PHI_W-1:0];
    pt1_r    <= rd_pt;
    eta_sq_r <= eta_prod[27:0];
    phi_sq_r <= phi_prod[23:0];
    pt2_r    <= pt1_r;
  end

  logic [SW-1:0]             sum_r;
  logic [hcti_pkg::PT_W-1:0] lead_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_seed) begin
      sum_r  <= '0;
      lead_r <= '0;
    end else if (v2_r && in_cone) begin
      sum_r <= sum_r + SW'(pt2_r);
      if (pt2_r > lead_r) lead_r <= pt2_r;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic                      div_busy_r, den_zero_r;
  logic [DCW-1:0]            div_cnt_r;
  logic [NW-1:0]             q_r;
  logic [hcti_pkg::PT_W-1:0] den_r, rem_r, den_sel;
  logic [hcti_pkg::PT_W:0]   rem_sh, diff;
  logic                      ge;
  logic [hcti_pkg::TIV_W-1:0] ratio;

  assign den_sel = (lead_r > seed_pt_r) ? lead_r : seed_pt_r;
  assign rem_sh  = {rem_r, q_r[NW-1]};
  assign diff    = rem_sh - {1'b0, den_r};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign ratio   = den_zero_r ? '0 : ((|q_r[NW-1:16]) ? 16'hFFFF : q_r[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= DCW'(NW);
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r - DCW'(1);
      if (div_cnt_r == DCW'(1)) div_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r        <= {sum_r, 8'd0};
      rem_r      <= '0;
      den_r      <= den_sel;
      den_zero_r <= (den_sel == '0);
    end else if (div_busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? diff[hcti_pkg::PT_W-1:0] : rem_sh[hcti_pkg::PT_W-1:0];
    end
  end

  logic                       any_seed_r;
  logic [hcti_pkg::TIV_W-1:0] best_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_scan) begin
      any_seed_r <= 1'b0;
    end else if (cmd.upd_best) begin
      any_seed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd_best && (!any_seed_r || ratio < best_r)) best_r <= ratio;
  end

  // result register
  logic                       out_valid_r;
  logic [hcti_pkg::TIV_W-1:0] out_ratio_r;
  logic                       out_no_seed_r, out_accept_r, out_dropped_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ratio_r   <= any_seed_r ? best_r : '0;
      out_no_seed_r <= !any_seed_r;
      out_accept_r  <= !mode_r[1] || (any_seed_r && best_r >= min_tiv_r);
      out_dropped_r <= overflow_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_min_isolation_ratio = out_ratio_r;
  assign out_no_seed             = out_no_seed_r;
  assign out_event_accept        = out_accept_r;
  assign out_tracks_dropped      = out_dropped_r;

  assign sts.i_done      = (i_r == count_r);
  assign sts.is_seed     = (rd_pt >= seed_min_pt_r);
  assign sts.j_last      = (j_r == count_r - CW'(1));
  assign sts.pipe_busy   = v0_r || v1_r || v2_r;
  assign sts.div_busy    = div_busy_r;
  assign sts.out_blocked = out_valid_r && out_stall;

endmodule

### design/hollow_cone_track_isolation.sv
// hollow_cone_track_isolation: top level, joins the sequencer and the datapath.
// Depends on hcti_pkg, hcti_ctrl and hcti_dp.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  track fields, one beat per track
//   out      output     out_valid/out_stall one beat per event
//   cfg      input      cfg_we             cfg_index, cfg_wdata
//
// Tracks load at one beat per cycle. After the last beat, each stored track
// is read and then checked against the seed cut; each seed adds a scan of all
// stored tracks, a drain of the distance pipeline, a serial divide and an update.
// A final read step and the finish step close the event; finish waits while the
// previous result is stalled.
// rst_n is synchronous; after reset the store is empty.
// A finished result waits in the output register while the next event loads.
module hollow_cone_track_isolation #(
  parameter int unsigned MAX_TRACKS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hcti_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hcti_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [hcti_pkg::PT_W-1:0]            in_track_pt,
  input  logic signed [hcti_pkg::ETA_W-1:0]    in_track_eta,
  input  logic signed [hcti_pkg::PHI_W-1:0]    in_track_phi,
  input  logic [hcti_pkg::THIT_W-1:0]          in_tracker_hit_count,
  input  logic [hcti_pkg::PHIT_W-1:0]          in_pixel_hit_count,
  input  logic                                 in_high_purity,
  input  logic                                 in_last_track,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hcti_pkg::TIV_W-1:0]           out_min_isolation_ratio,
  output logic                                 out_no_seed,
  output logic                                 out_event_accept,
  output logic                                 out_tracks_dropped
);

  hcti_pkg::hcti_cmd_t cmd;
  hcti_pkg::hcti_sts_t sts;

  assign in_stall = !cmd.load_en;

  hcti_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_track (in_last_track),
    .sts           (sts),
    .cmd           (cmd)
  );

  hcti_dp #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_track_pt             (in_track_pt),
    .in_track_eta            (in_track_eta),
    .in_track_phi            (in_track_phi),
    .in_tracker_hit_count    (in_tracker_hit_count),
    .in_pixel_hit_count      (in_pixel_hit_count),
    .in_high_purity          (in_high_purity),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_min_isolation_ratio (out_min_isolation_ratio),
    .out_no_seed             (out_no_seed),
    .out_event_accept        (out_event_accept),
    .out_tracks_dropped      (out_tracks_dropped),
    .cmd                     (cmd),
    .sts                     (sts)
  );

  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_track) |=> in_stall)
    else $error("load continued after last track");

  a_no_seed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_seed) |-> (out_min_isolation_ratio == '0))
    else $error("no-seed result carries nonzero ratio");

  a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while loading");

endmodule
